// ===== src/can_frame_binary_serializer_core_assert.svh =====
// Assertion macros used by the serializer top level.
`ifndef CAN_FRAME_BINARY_SERIALIZER_CORE_ASSERT_SVH
`define CAN_FRAME_BINARY_SERIALIZER_CORE_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define CFBS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define CFBS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `CFBS_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

// ===== src/cfbs_pkg.sv =====
// Types and constants of the CAN frame binary serializer.
`default_nettype none
package cfbs_pkg;

  localparam logic [7:0] SyncByte = 8'hF1;
  localparam logic [7:0] TypeCan  = 8'h00;

  // Byte positions inside a packet
  localparam int PosSync  = 0;
  localparam int PosType  = 1;
  localparam int PosTs0   = 2;
  localparam int PosId0   = 6;
  localparam int PosLen   = 10;
  localparam int PosData0 = 11;

  typedef struct packed {
    logic [31:0] timestamp;
    logic [28:0] frame_id;
    logic        extended;
    logic [3:0]  bus_number;
    logic [3:0]  data_length;  // already clamped
    logic [63:0] payload;
  } frame_t;

endpackage
`default_nettype wire

// ===== src/cfbs_if.sv =====
// Handshake channels: frame words in, packet byte words out.
`default_nettype none
interface cfbs_frame_if;
  logic        valid;
  logic        ready;
  logic [31:0] timestamp;
  logic [28:0] frame_id;
  logic        extended;
  logic [3:0]  bus_number;
  logic [3:0]  data_length;
  logic [63:0] payload;

  modport source (output valid, timestamp, frame_id, extended, bus_number, data_length,
                  payload, input ready);
  modport sink   (input valid, timestamp, frame_id, extended, bus_number, data_length,
                  payload, output ready);
endinterface

interface cfbs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface
`default_nettype wire

// ===== src/cfbs_frame_reg.sv =====
// Input register: holds one frame word with its length clamped.
`default_nettype none
module cfbs_frame_reg
  import cfbs_pkg::*;
#(
  parameter int MAX_DATA_BYTES = 8
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  cfbs_frame_if.sink  in_i,
  input  wire logic   pop_i,
  output frame_t      frame_o,
  output logic        valid_o
);

  logic   valid_q, valid_d;
  frame_t frame_q, frame_d;
  logic   accept;

  assign in_i.ready = !valid_q || pop_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    frame_d = frame_q;
    valid_d = valid_q;
    if (accept) begin
      frame_d.timestamp  = in_i.timestamp;
      frame_d.frame_id   = in_i.frame_id;
      frame_d.extended   = in_i.extended;
      frame_d.bus_number = in_i.bus_number;
      frame_d.payload    = in_i.payload;
      // clamp oversize lengths
      if (in_i.data_length > 4'(MAX_DATA_BYTES)) begin
        frame_d.data_length = 4'(MAX_DATA_BYTES);
      end else begin
        frame_d.data_length = in_i.data_length;
      end
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
  end

  assign frame_o = frame_q;
  assign valid_o = valid_q;

endmodule
`default_nettype wire

// ===== src/cfbs_byte_sel.sv =====
// Byte select: picks the packet byte at a given position of the frame.
`default_nettype none
module cfbs_byte_sel
  import cfbs_pkg::*;
#(
  parameter int IdxW = 5
) (
  input  wire frame_t            frame_i,
  input  wire logic [IdxW-1:0]   idx_i,
  output logic [7:0]             byte_o
);

  logic [31:0] id_word;
  logic [1:0]  ts_off;
  logic [1:0]  id_off;
  logic [2:0]  data_off;

  assign id_word  = {frame_i.extended, 2'b00, frame_i.frame_id};
  assign ts_off   = 2'(idx_i - IdxW'(PosTs0));
  assign id_off   = 2'(idx_i - IdxW'(PosId0));
  assign data_off = 3'(idx_i - IdxW'(PosData0));

  always_comb begin
    if (idx_i == IdxW'(PosSync)) begin
      byte_o = SyncByte;
    end else if (idx_i == IdxW'(PosType)) begin
      byte_o = TypeCan;
    end else if (idx_i < IdxW'(PosId0)) begin
      byte_o = 8'(frame_i.timestamp >> {ts_off, 3'b000});
    end else if (idx_i < IdxW'(PosLen)) begin
      byte_o = 8'(id_word >> {id_off, 3'b000});
    end else if (idx_i == IdxW'(PosLen)) begin
      byte_o = {frame_i.bus_number, frame_i.data_length};
    end else begin
      byte_o = frame_i.payload[{data_off, 3'b000} +: 8];
    end
  end

endmodule
`default_nettype wire

// ===== src/can_frame_binary_serializer_core.sv =====
// Top level: CAN frame to binary packet byte stream serializer.
// The sync byte of an accepted frame passes the frame register and then the output register.
// Throughput: one byte per cycle while the output is ready, set by the single byte-wide output register;
// a packet is 12 + clamped length bytes (12 to 20) and the next frame enters as the checksum goes.
// Reset: asynchronous active low; clears the frame and output valid flags,
// the byte index and the running checksum.
`default_nettype none
`include "can_frame_binary_serializer_core_assert.svh"
module can_frame_binary_serializer_core
  import cfbs_pkg::*;
#(
  parameter int MAX_DATA_BYTES = 8
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  cfbs_frame_if.sink   in_i,
  cfbs_byte_if.source  out_o
);

  // Longest packet: header, length byte, payload, checksum.
  localparam int MaxPacketBytes = PosData0 + MAX_DATA_BYTES + 1;
  localparam int IdxW           = $clog2(MaxPacketBytes);

  frame_t            frame;
  logic              frame_valid;
  logic              pop;

  logic [IdxW-1:0]   idx_q, idx_d;
  logic [7:0]        sum_q, sum_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;

  logic [7:0]        sel_byte;
  logic [IdxW-1:0]   last_idx;
  logic              is_last;
  logic              load;
  logic              emit;

  // Hold the frame until its checksum byte is loaded into the output register.
  cfbs_frame_reg #(
    .MAX_DATA_BYTES (MAX_DATA_BYTES)
  ) u_frame_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .pop_i   (pop),
    .frame_o (frame),
    .valid_o (frame_valid)
  );

  // Select the packet byte at the current index.
  cfbs_byte_sel #(
    .IdxW (IdxW)
  ) u_byte_sel (
    .frame_i (frame),
    .idx_i   (idx_q),
    .byte_o  (sel_byte)
  );

  // Checksum position follows the clamped payload length.
  assign last_idx = IdxW'(PosData0) + IdxW'(frame.data_length);
  assign is_last  = (idx_q == last_idx);

  // Output register loads when empty or when its word is taken.
  assign load = !out_valid_q || out_o.ready;
  assign emit = load && frame_valid;
  assign pop  = emit && is_last;

  always_comb begin
    idx_d       = idx_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_last_d  = is_last;
      if (is_last) begin
        // send the running XOR and restart for the next frame
        out_byte_d = sum_q;
        idx_d      = '0;
        sum_d      = '0;
      end else begin
        out_byte_d = sel_byte;
        idx_d      = idx_q + IdxW'(1);
        sum_d      = sum_q ^ sel_byte;
      end
    end else if (load) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.last     = out_last_q;

  `CFBS_ASSERT(a_idx_in_packet, clk_i, rst_ni, frame_valid |-> (idx_q <= last_idx), "byte index beyond checksum position")
  `CFBS_ASSERT(a_sum_clear_at_start, clk_i, rst_ni, (idx_q == '0) |-> (sum_q == '0), "checksum not cleared at packet start")
  `CFBS_ASSERT(a_last_restarts, clk_i, rst_ni, pop |=> (idx_q == '0) && out_last_q, "checksum byte did not end the packet")
  `CFBS_ASSERT_NEVER(a_idle_index, clk_i, rst_ni, !frame_valid && (idx_q != '0), "byte index moved without a frame")

endmodule
`default_nettype wire
